/* rtl/avrex_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// avrex_pkg
// Shared types and defaults for the AVR subset execute core.
// ----------------------------------------------------------------------------
package avrex_pkg;

	localparam int DATA_BYTES_DEF = 512;
	localparam int PC_WIDTH_DEF   = 11;

	typedef enum logic [3:0] {
		CL_NONE,
		CL_MOVW,
		CL_ADD,
		CL_MOV,
		CL_COM,
		CL_IN,
		CL_LD,
		CL_ST,
		CL_LDI,
		CL_PUSH
	} cls_t;

	typedef struct packed {
		cls_t       cls;
		logic [4:0] d;
		logic [4:0] r;
		logic [5:0] q;
		logic [7:0] k;
	} op_t;

	typedef struct packed {
		logic halted;
		logic unimpl;
	} res_t;

endpackage
`default_nettype wire

/* rtl/avr_subset_execute_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// avr_subset_execute_core
// Executes a subset of AVR instructions against a unified data space.
//
// The input channel is a queue write port: an instruction word, in program
// memory byte order, transfers when push is high and full is low. The output
// channel is a queue read port: while empty is low the oldest result is on
// next_pc, halted, unimplemented and status_flags, and it transfers when pop
// is high. Every instruction gives exactly one result, in order.
// A front part decodes each word and tracks the program counter and halt
// flag; a two-entry queue feeds a back part that runs each instruction as a
// sequence of single-port data memory accesses. The back part picks up an
// operation from the queue and then runs its steps: one step for NOP,
// RJMP, BREAK, LDI and undefined words, two for MOV and IN, three for COM,
// four for ADD and MOVW, five for ST, six for LD and seven for PUSH.
// After reset the data space is cleared one byte per cycle, all DATA_BYTES
// bytes, with full held high. When the receiver stalls, one result waits
// in the output register, the back part holds one more at its last step
// and the queue absorbs up to two further items.
// ----------------------------------------------------------------------------
module avr_subset_execute_core #(
	parameter int DATA_BYTES = avrex_pkg::DATA_BYTES_DEF,
	parameter int PC_WIDTH   = avrex_pkg::PC_WIDTH_DEF
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      push,
	output logic                     full,
	input  wire  [15:0]              instr_word,
	output logic                     empty,
	input  wire                      pop,
	output logic [PC_WIDTH-1:0]      next_pc,
	output logic                     halted,
	output logic                     unimplemented,
	output logic [7:0]               status_flags
);
	import avrex_pkg::*;

	op_t                 f_op;
	logic [PC_WIDTH-1:0] f_pc;
	res_t                f_res;
	op_t                 b_op;
	logic [PC_WIDTH-1:0] b_pc;
	res_t                b_res;
	res_t                o_res;
	logic                q_full;
	logic                q_empty;
	logic                q_pop;
	logic                clearing;
	logic                out_valid;
	logic                accept;

	assign full          = q_full || clearing;
	assign accept        = push && !full;
	assign empty         = !out_valid;
	assign halted        = o_res.halted;
	assign unimplemented = o_res.unimpl;

	avrex_front #(.PC_WIDTH(PC_WIDTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.instr_word (instr_word),
		.op         (f_op),
		.pc_next    (f_pc),
		.res        (f_res)
	);

	avrex_queue #(.PC_WIDTH(PC_WIDTH)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (accept),
		.wr_op   (f_op),
		.wr_pc   (f_pc),
		.wr_res  (f_res),
		.q_full  (q_full),
		.rd      (q_pop),
		.rd_op   (b_op),
		.rd_pc   (b_pc),
		.rd_res  (b_res),
		.q_empty (q_empty)
	);

	avrex_back #(.DATA_BYTES(DATA_BYTES), .PC_WIDTH(PC_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_op     (b_op),
		.in_pc     (b_pc),
		.in_res    (b_res),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.clearing  (clearing),
		.out_valid (out_valid),
		.out_pop   (pop),
		.out_pc    (next_pc),
		.out_res   (o_res),
		.out_sreg  (status_flags)
	);

endmodule
`default_nettype wire

/* rtl/avrex_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// avrex_front
// Accepts instruction words, decodes them into operation classes and keeps
// the program counter and the halt flag.
// ----------------------------------------------------------------------------
module avrex_front #(
	parameter int PC_WIDTH = 11
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      accept,
	input  wire  [15:0]              instr_word,
	output avrex_pkg::op_t           op,
	output logic [PC_WIDTH-1:0]      pc_next,
	output avrex_pkg::res_t          res
);
	import avrex_pkg::*;

	logic [PC_WIDTH-1:0] pc_q;
	logic                halt_q;
	logic [15:0]         w;
	logic [15:0]         rel;
	logic [PC_WIDTH-1:0] step;

	assign w   = {instr_word[7:0], instr_word[15:8]};
	assign rel = {{4{w[11]}}, w[11:0]};

	always_comb begin
		op.cls = CL_NONE;
		op.d   = w[8:4];
		op.r   = {w[9], w[3:0]};
		op.q   = {w[13], w[11:10], w[2:0]};
		op.k   = {w[11:8], w[3:0]};
		step   = PC_WIDTH'(1);
		res.halted = halt_q;
		res.unimpl = 1'b0;
		if (halt_q) begin
			step = '0;
		end else if (w == 16'h0000) begin
			op.cls = CL_NONE;
		end else if ((w & 16'hFF00) == 16'h0100) begin
			op.cls = CL_MOVW;
			op.d   = {w[7:4], 1'b0};
			op.r   = {w[3:0], 1'b0};
		end else if ((w & 16'hFC00) == 16'h0C00) begin
			op.cls = CL_ADD;
		end else if ((w & 16'hFC00) == 16'h2C00) begin
			op.cls = CL_MOV;
		end else if ((w & 16'hFE0F) == 16'h9400) begin
			op.cls = CL_COM;
		end else if ((w & 16'hF800) == 16'hB000) begin
			op.cls = CL_IN;
			op.q   = {w[10:9], w[3:0]};
		end else if ((w & 16'hD208) == 16'h8000) begin
			op.cls = CL_LD;
		end else if ((w & 16'hD208) == 16'h8200) begin
			op.cls = CL_ST;
		end else if ((w & 16'hF000) == 16'hE000) begin
			op.cls = CL_LDI;
			op.d   = {1'b1, w[7:4]};
		end else if ((w & 16'hFE0F) == 16'h920F) begin
			op.cls = CL_PUSH;
		end else if ((w & 16'hF000) == 16'hC000) begin
			step = PC_WIDTH'(1) + rel[PC_WIDTH-1:0];
		end else if (w == 16'h9598) begin
			res.halted = 1'b1;
		end else begin
			res.halted = 1'b1;
			res.unimpl = 1'b1;
		end
		pc_next = pc_q + step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			halt_q <= 1'b0;
		end else if (accept) begin
			pc_q   <= pc_next;
			halt_q <= res.halted;
		end
	end

endmodule
`default_nettype wire

/* rtl/avrex_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// avrex_queue
// Two-entry queue of decoded operations between the front and back parts.
// ----------------------------------------------------------------------------
module avrex_queue #(
	parameter int PC_WIDTH = 11
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      wr,
	input  wire  avrex_pkg::op_t     wr_op,
	input  wire  [PC_WIDTH-1:0]      wr_pc,
	input  wire  avrex_pkg::res_t    wr_res,
	output logic                     q_full,
	input  wire                      rd,
	output avrex_pkg::op_t           rd_op,
	output logic [PC_WIDTH-1:0]      rd_pc,
	output avrex_pkg::res_t          rd_res,
	output logic                     q_empty
);
	import avrex_pkg::*;

	op_t                 op_q  [2];
	logic [PC_WIDTH-1:0] pc_q  [2];
	res_t                res_q [2];
	logic                wp_q;
	logic                rp_q;
	logic [1:0]          cnt_q;

	assign q_full  = (cnt_q == 2'd2);
	assign q_empty = (cnt_q == 2'd0);
	assign rd_op   = op_q[rp_q];
	assign rd_pc   = pc_q[rp_q];
	assign rd_res  = res_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			op_q[wp_q]  <= wr_op;
			pc_q[wp_q]  <= wr_pc;
			res_q[wp_q] <= wr_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= ~wp_q;
			end
			if (rd) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty |-> !rd) else $error("read from empty queue");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(q_full && !rd) |-> !wr) else $error("write to full queue");

endmodule
`default_nettype wire

/* rtl/avrex_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// avrex_back
// Executes decoded operations step by step against the single-port data
// space and holds the finished result for the output side.
// ----------------------------------------------------------------------------
module avrex_back #(
	parameter int DATA_BYTES = 512,
	parameter int PC_WIDTH   = 11
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire  avrex_pkg::op_t     in_op,
	input  wire  [PC_WIDTH-1:0]      in_pc,
	input  wire  avrex_pkg::res_t    in_res,
	input  wire                      q_empty,
	output logic                     q_pop,
	output logic                     clearing,
	output logic                     out_valid,
	input  wire                      out_pop,
	output logic [PC_WIDTH-1:0]      out_pc,
	output avrex_pkg::res_t          out_res,
	output logic [7:0]               out_sreg
);
	import avrex_pkg::*;

	localparam int AW    = $clog2(DATA_BYTES);
	localparam int RAW_W = 17;
	localparam int SH    = RAW_W + AW;
	localparam logic [SH:0] RECIP = (SH+1)'((2**SH + DATA_BYTES - 1) / DATA_BYTES);
	localparam logic [AW-1:0] A_ZL   = AW'(7'h1E);
	localparam logic [AW-1:0] A_ZH   = AW'(7'h1F);
	localparam logic [AW-1:0] A_SPL  = AW'(7'h5D);
	localparam logic [AW-1:0] A_SPH  = AW'(7'h5E);
	localparam logic [AW-1:0] A_SREG = AW'(7'h5F);
	localparam logic [AW-1:0] A_LAST = AW'(DATA_BYTES - 1);

	logic [7:0]          mem [DATA_BYTES];
	logic [7:0]          rd_q;
	op_t                 cur_op_q;
	logic [PC_WIDTH-1:0] cur_pc_q;
	res_t                cur_res_q;
	logic                cur_valid_q;
	logic [2:0]          step_q;
	logic [7:0]          t0_q;
	logic [7:0]          t1_q;
	logic [RAW_W-1:0]    raw_q;
	logic [RAW_W-1:0]    quo_q;
	logic [15:0]         sp_q;
	logic [7:0]          sreg_q;
	logic                clr_q;
	logic [AW-1:0]       clr_cnt_q;
	logic                out_valid_q;

	logic                m_we;
	logic [AW-1:0]       m_addr;
	logic [7:0]          m_wdata;
	logic                last;
	logic                ld_t0;
	logic                ld_t1;
	logic [7:0]          t1_d;
	logic                ld_raw;
	logic [RAW_W-1:0]    raw_d;
	logic                ld_sp;
	logic [RAW_W+SH:0]   prod;
	logic [RAW_W-1:0]    diff;
	logic [AW-1:0]       mod_addr;
	logic [AW-1:0]       d_addr;
	logic [7:0]          sum;
	logic [7:0]          inv;
	logic [7:0]          add_sreg;
	logic [7:0]          com_sreg;
	logic [15:0]         sp_dec;
	logic                stall;
	logic                adv;
	logic                finish;
	logic                e_we;
	logic [AW-1:0]       e_addr;
	logic [7:0]          e_wdata;
	logic [7:0]          sreg_next;

	assign prod     = raw_q * RECIP;
	assign diff     = raw_q - RAW_W'(quo_q * RAW_W'(DATA_BYTES));
	assign mod_addr = diff[AW-1:0];
	assign d_addr   = AW'(cur_op_q.d);
	assign sum      = t0_q + rd_q;
	assign inv      = ~rd_q;
	assign sp_dec   = sp_q - 16'd1;

	always_comb begin
		add_sreg    = sreg_q;
		add_sreg[5] = (t0_q[3] & rd_q[3]) | (rd_q[3] & ~sum[3]) | (~sum[3] & t0_q[3]);
		add_sreg[3] = (t0_q[7] & rd_q[7] & ~sum[7]) | (~t0_q[7] & ~rd_q[7] & sum[7]);
		add_sreg[2] = sum[7];
		add_sreg[4] = sum[7] ^ add_sreg[3];
		add_sreg[1] = (sum == 8'd0);
		add_sreg[0] = (t0_q[7] & rd_q[7]) | (rd_q[7] & ~sum[7]) | (~sum[7] & t0_q[7]);
		com_sreg    = sreg_q;
		com_sreg[3] = 1'b0;
		com_sreg[2] = inv[7];
		com_sreg[4] = inv[7];
		com_sreg[1] = (inv == 8'd0);
		com_sreg[0] = 1'b1;
	end

	always_comb begin
		m_we    = 1'b0;
		m_addr  = '0;
		m_wdata = rd_q;
		last    = 1'b0;
		ld_t0   = 1'b0;
		ld_t1   = 1'b0;
		t1_d    = rd_q;
		ld_raw  = 1'b0;
		raw_d   = {1'b0, rd_q, t0_q} + RAW_W'(cur_op_q.q);
		ld_sp   = 1'b0;
		unique case (cur_op_q.cls)
			CL_MOVW: begin
				unique case (step_q)
					3'd0: m_addr = AW'(cur_op_q.r);
					3'd1: begin
						m_addr = AW'({cur_op_q.r[4:1], 1'b1});
						ld_t0  = 1'b1;
					end
					3'd2: begin
						m_we    = 1'b1;
						m_addr  = d_addr;
						m_wdata = t0_q;
						ld_t1   = 1'b1;
					end
					default: begin
						m_we    = 1'b1;
						m_addr  = AW'({cur_op_q.d[4:1], 1'b1});
						m_wdata = t1_q;
						last    = 1'b1;
					end
				endcase
			end
			CL_ADD: begin
				unique case (step_q)
					3'd0: m_addr = d_addr;
					3'd1: begin
						m_addr = AW'(cur_op_q.r);
						ld_t0  = 1'b1;
					end
					3'd2: begin
						m_we    = 1'b1;
						m_addr  = d_addr;
						m_wdata = sum;
						ld_t1   = 1'b1;
						t1_d    = add_sreg;
					end
					default: begin
						m_we    = 1'b1;
						m_addr  = A_SREG;
						m_wdata = t1_q;
						last    = 1'b1;
					end
				endcase
			end
			CL_MOV, CL_IN: begin
				if (step_q == 3'd0) begin
					m_addr = (cur_op_q.cls == CL_IN) ? AW'(7'h20 + {1'b0, cur_op_q.q})
						: AW'(cur_op_q.r);
				end else begin
					m_we   = 1'b1;
					m_addr = d_addr;
					last   = 1'b1;
				end
			end
			CL_COM: begin
				unique case (step_q)
					3'd0: m_addr = d_addr;
					3'd1: begin
						m_we    = 1'b1;
						m_addr  = d_addr;
						m_wdata = inv;
						ld_t1   = 1'b1;
						t1_d    = com_sreg;
					end
					default: begin
						m_we    = 1'b1;
						m_addr  = A_SREG;
						m_wdata = t1_q;
						last    = 1'b1;
					end
				endcase
			end
			CL_LD: begin
				unique case (step_q)
					3'd0: m_addr = A_ZL;
					3'd1: begin
						m_addr = A_ZH;
						ld_t0  = 1'b1;
					end
					3'd2: ld_raw = 1'b1;
					3'd3: m_addr = '0;
					3'd4: m_addr = mod_addr;
					default: begin
						m_we   = 1'b1;
						m_addr = d_addr;
						last   = 1'b1;
					end
				endcase
			end
			CL_ST: begin
				unique case (step_q)
					3'd0: m_addr = A_ZL;
					3'd1: begin
						m_addr = A_ZH;
						ld_t0  = 1'b1;
					end
					3'd2: begin
						ld_raw = 1'b1;
						m_addr = d_addr;
					end
					3'd3: ld_t1 = 1'b1;
					default: begin
						m_we    = 1'b1;
						m_addr  = mod_addr;
						m_wdata = t1_q;
						last    = 1'b1;
					end
				endcase
			end
			CL_LDI: begin
				m_we    = 1'b1;
				m_addr  = d_addr;
				m_wdata = cur_op_q.k;
				last    = 1'b1;
			end
			CL_PUSH: begin
				unique case (step_q)
					3'd0: m_addr = A_SPL;
					3'd1: begin
						m_addr = A_SPH;
						ld_t0  = 1'b1;
					end
					3'd2: begin
						ld_raw = 1'b1;
						raw_d  = {1'b0, rd_q, t0_q};
						ld_sp  = 1'b1;
						m_addr = d_addr;
					end
					3'd3: ld_t1 = 1'b1;
					3'd4: begin
						m_we    = 1'b1;
						m_addr  = mod_addr;
						m_wdata = t1_q;
					end
					3'd5: begin
						m_we    = 1'b1;
						m_addr  = A_SPL;
						m_wdata = sp_dec[7:0];
					end
					default: begin
						m_we    = 1'b1;
						m_addr  = A_SPH;
						m_wdata = sp_dec[15:8];
						last    = 1'b1;
					end
				endcase
			end
			default: last = 1'b1;
		endcase
	end

	assign stall     = cur_valid_q && last && out_valid_q && !out_pop;
	assign adv       = cur_valid_q && !stall && !clr_q;
	assign finish    = adv && last;
	assign q_pop     = !clr_q && !q_empty && (!cur_valid_q || finish);
	assign e_we      = clr_q || (adv && m_we);
	assign e_addr    = clr_q ? clr_cnt_q : m_addr;
	assign e_wdata   = clr_q ? 8'd0 : m_wdata;
	assign sreg_next = (e_we && e_addr == A_SREG) ? e_wdata : sreg_q;
	assign clearing  = clr_q;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (e_we) begin
			mem[e_addr] <= e_wdata;
		end
		if (adv) begin
			rd_q <= mem[e_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_op_q  <= in_op;
			cur_pc_q  <= in_pc;
			cur_res_q <= in_res;
		end
		if (adv) begin
			quo_q <= prod[SH +: RAW_W];
			if (ld_t0) begin
				t0_q <= rd_q;
			end
			if (ld_t1) begin
				t1_q <= t1_d;
			end
			if (ld_raw) begin
				raw_q <= raw_d;
			end
			if (ld_sp) begin
				sp_q <= {rd_q, t0_q};
			end
		end
		if (finish) begin
			out_pc   <= cur_pc_q;
			out_res  <= cur_res_q;
			out_sreg <= sreg_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= 1'b1;
			clr_cnt_q   <= '0;
			cur_valid_q <= 1'b0;
			step_q      <= '0;
			sreg_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			sreg_q <= sreg_next;
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
				if (clr_cnt_q == A_LAST) begin
					clr_q <= 1'b0;
				end
			end
			if (q_pop) begin
				cur_valid_q <= 1'b1;
				step_q      <= '0;
			end else if (finish) begin
				cur_valid_q <= 1'b0;
			end else if (adv) begin
				step_q <= step_q + 3'd1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty) else $error("pop from empty operation queue");
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !cur_valid_q) else $error("operation active during clear");
	a_finish_out: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> out_valid_q) else $error("finished result not held");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> step_q <= 3'd6) else $error("step counter out of range");

endmodule
`default_nettype wire

/* sim/tb_avr_subset_execute_core.sv */
// ----------------------------------------------------------------------------
// tb_avr_subset_execute_core
// Self-checking testbench for the AVR subset execute core.
//
// A queue of instruction words, directed then random, feeds a push-side
// driver with random gaps. An internal predictor executes each accepted word
// against its own copy of the data space, program counter and halt flag. A
// pop-side monitor with random stalls compares every result with the oldest
// prediction. The run ends with a halting word and a few words sent while
// the core is halted.
// ----------------------------------------------------------------------------
module tb_avr_subset_execute_core;
	timeunit 1ns;
	timeprecision 1ps;
	import avrex_pkg::*;

	localparam int NBYTES = DATA_BYTES_DEF;
	localparam int PCW    = PC_WIDTH_DEF;
	localparam int LIMIT  = 400000;

	localparam logic [15:0] OP_NOP   = 16'h0000;
	localparam logic [15:0] OP_MOVW  = 16'h0100;
	localparam logic [15:0] OP_ADD   = 16'h0C00;
	localparam logic [15:0] OP_MOV   = 16'h2C00;
	localparam logic [15:0] OP_COM   = 16'h9400;
	localparam logic [15:0] OP_IN    = 16'hB000;
	localparam logic [15:0] OP_LDD   = 16'h8000;
	localparam logic [15:0] OP_STD   = 16'h8200;
	localparam logic [15:0] OP_LDI   = 16'hE000;
	localparam logic [15:0] OP_PUSH  = 16'h920F;
	localparam logic [15:0] OP_RJMP  = 16'hC000;
	localparam logic [15:0] OP_BREAK = 16'h9598;
	localparam logic [15:0] OP_UNDEF = 16'hFFFF;

	localparam int ADR_SPL  = 'h5D;
	localparam int ADR_SPH  = 'h5E;
	localparam int ADR_SREG = 'h5F;
	localparam int IO_BASE  = 'h20;

	localparam int F_C = 0;
	localparam int F_Z = 1;
	localparam int F_N = 2;
	localparam int F_V = 3;
	localparam int F_S = 4;
	localparam int F_H = 5;

	typedef struct {
		logic [PCW-1:0] pc;
		logic           halted;
		logic           unimpl;
		logic [7:0]     sreg;
	} outcome_t;

	logic           clk;
	logic           arst_n;
	logic           push;
	logic           full;
	logic [15:0]    instr_word;
	logic           empty;
	logic           pop;
	logic [PCW-1:0] next_pc;
	logic           halted;
	logic           unimplemented;
	logic [7:0]     status_flags;

	avr_subset_execute_core u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .instr_word(instr_word),
		.empty(empty), .pop(pop), .next_pc(next_pc), .halted(halted),
		.unimplemented(unimplemented), .status_flags(status_flags)
	);

	logic [7:0]     dmem [NBYTES];
	logic [PCW-1:0] core_pc;
	logic           core_halt;
	logic [15:0]    pending_words [$];
	outcome_t       expected_outcomes [$];
	int             errors;
	int             words_in;
	int             words_out;
	int             cycles;
	int             push_gap;
	int             pop_gap;
	bit             push_burst;
	bit             pop_burst;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic logic [7:0] rd(int a);
		return dmem[a % NBYTES];
	endfunction

	function automatic void wr(int a, logic [7:0] v);
		dmem[a % NBYTES] = v;
	endfunction

	function automatic void execute_word(logic [15:0] w);
		logic [15:0] op;
		logic [4:0]  d5;
		logic [4:0]  r5;
		logic [5:0]  q;
		logic [7:0]  a;
		logic [7:0]  b;
		logic [7:0]  r;
		logic [7:0]  s;
		logic [15:0] ptr;
		logic        unimpl;
		outcome_t    o;
		op = {w[7:0], w[15:8]};
		d5 = op[8:4];
		r5 = {op[9], op[3:0]};
		q = {op[13], op[11:10], op[2:0]};
		unimpl = 1'b0;
		if (!core_halt) begin
			s = rd(ADR_SREG);
			if (op == OP_NOP) begin
			end else if ((op & 16'hFF00) == OP_MOVW) begin
				a = rd(op[3:0] * 2);
				b = rd(op[3:0] * 2 + 1);
				wr(op[7:4] * 2, a);
				wr(op[7:4] * 2 + 1, b);
			end else if ((op & 16'hFC00) == OP_ADD) begin
				a = rd(d5);
				b = rd(r5);
				r = a + b;
				wr(d5, r);
				s = rd(ADR_SREG);
				s[F_H] = (a[3] & b[3]) | (b[3] & ~r[3]) | (~r[3] & a[3]);
				s[F_V] = (a[7] & b[7] & ~r[7]) | (~a[7] & ~b[7] & r[7]);
				s[F_N] = r[7];
				s[F_S] = r[7] ^ s[F_V];
				s[F_Z] = (r == 8'h00);
				s[F_C] = (a[7] & b[7]) | (b[7] & ~r[7]) | (~r[7] & a[7]);
				wr(ADR_SREG, s);
			end else if ((op & 16'hFC00) == OP_MOV) begin
				wr(d5, rd(r5));
			end else if ((op & 16'hFE0F) == OP_COM) begin
				r = ~rd(d5);
				wr(d5, r);
				s = rd(ADR_SREG);
				s[F_V] = 1'b0;
				s[F_N] = r[7];
				s[F_S] = r[7];
				s[F_Z] = (r == 8'h00);
				s[F_C] = 1'b1;
				wr(ADR_SREG, s);
			end else if ((op & 16'hF800) == OP_IN) begin
				wr(d5, rd(IO_BASE + {op[10:9], op[3:0]}));
			end else if ((op & 16'hD208) == OP_LDD) begin
				ptr = {rd(31), rd(30)};
				wr(d5, rd(ptr + q));
			end else if ((op & 16'hD208) == OP_STD) begin
				ptr = {rd(31), rd(30)};
				wr(ptr + q, rd(d5));
			end else if ((op & 16'hF000) == OP_LDI) begin
				wr(16 + op[7:4], {op[11:8], op[3:0]});
			end else if ((op & 16'hFE0F) == OP_PUSH) begin
				ptr = {rd(ADR_SPH), rd(ADR_SPL)};
				wr(ptr, rd(d5));
				ptr = ptr - 16'd1;
				wr(ADR_SPL, ptr[7:0]);
				wr(ADR_SPH, ptr[15:8]);
			end else if ((op & 16'hF000) == OP_RJMP) begin
				core_pc = core_pc + op[PCW-1:0];
			end else if (op == OP_BREAK) begin
				core_halt = 1'b1;
			end else begin
				core_halt = 1'b1;
				unimpl = 1'b1;
			end
			core_pc = core_pc + 1'b1;
		end
		o.pc = core_pc;
		o.halted = core_halt;
		o.unimpl = unimpl;
		o.sreg = rd(ADR_SREG);
		expected_outcomes.push_back(o);
	endfunction

	task automatic send(logic [15:0] op);
		pending_words.push_back({op[7:0], op[15:8]});
	endtask

	function automatic logic [15:0] random_op();
		logic [15:0] x;
		int          pick;
		x = 16'($urandom);
		pick = $urandom_range(0, 21);
		case (pick)
			0: return OP_NOP;
			1: return OP_MOVW | (x & 16'h00FF);
			2, 3, 4: return OP_ADD | (x & 16'h03FF);
			5: return OP_MOV | (x & 16'h03FF);
			6, 7: return OP_COM | (x & 16'h01F0);
			8: return OP_IN | (x & 16'h07FF);
			9, 10: return OP_LDD | (x & 16'h2CF7);
			11, 12: return OP_STD | (x & 16'h2DF7);
			13: return OP_PUSH | (x & 16'h01F0);
			14: return OP_RJMP | (x & 16'h0FFF);
			15: return OP_LDI | (x & 16'h0F0F) | 16'h00E0;
			default: return OP_LDI | (x & 16'h0FFF);
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic nxt;
		if (!arst_n) begin
			push <= 1'b0;
			instr_word <= '0;
			push_gap = 0;
			push_burst = 1'b0;
		end else begin
			nxt = push;
			if (push && !full) begin
				execute_word(instr_word);
				words_in++;
				nxt = 1'b0;
				if ($urandom_range(0, 31) == 0)
					push_burst = !push_burst;
				push_gap = push_burst ? 0 : $urandom_range(0, 8);
			end
			if (!nxt) begin
				if (push_gap > 0) begin
					push_gap--;
				end else if (pending_words.size() > 0) begin
					instr_word <= pending_words.pop_front();
					nxt = 1'b1;
				end
			end
			push <= nxt;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		logic     nxt;
		outcome_t e;
		if (!arst_n) begin
			pop <= 1'b0;
			pop_gap = 0;
			pop_burst = 1'b0;
		end else begin
			nxt = pop;
			if (pop && !empty) begin
				words_out++;
				if (expected_outcomes.size() == 0) begin
					$error("result transfer with no prediction pending");
					errors++;
				end else begin
					e = expected_outcomes.pop_front();
					if (next_pc !== e.pc) begin
						$error("next_pc expected %0h actual %0h", e.pc, next_pc);
						errors++;
					end
					if (halted !== e.halted) begin
						$error("halted expected %0b actual %0b", e.halted, halted);
						errors++;
					end
					if (unimplemented !== e.unimpl) begin
						$error("unimplemented expected %0b actual %0b", e.unimpl,
							unimplemented);
						errors++;
					end
					if (status_flags !== e.sreg) begin
						$error("status_flags expected %0h actual %0h", e.sreg,
							status_flags);
						errors++;
					end
				end
				nxt = 1'b0;
				if ($urandom_range(0, 31) == 0)
					pop_burst = !pop_burst;
				pop_gap = pop_burst ? 0 : $urandom_range(0, 8);
			end
			if (!nxt) begin
				if (pop_gap > 0)
					pop_gap--;
				else
					nxt = 1'b1;
			end
			pop <= nxt;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		bit end_with_break;
		errors = 0;
		words_in = 0;
		words_out = 0;
		cycles = 0;
		core_pc = '0;
		core_halt = 1'b0;
		foreach (dmem[i])
			dmem[i] = 8'h00;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		instr_word = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		send(OP_NOP);
		send(OP_LDI | 16'h0F0F);
		send(OP_LDI | 16'h08F8);
		send(OP_LDI | 16'h0000 | 16'h0010);
		send(OP_ADD | 16'h0100 | 16'h0000);
		send(OP_ADD | 16'h0200 | 16'h0001);
		send(OP_LDI | 16'h0800 | 16'h0020);
		send(OP_ADD | 16'h0200 | 16'h0022);
		send(OP_COM | 16'h01F0);
		send(OP_COM | 16'h0000);
		send(OP_MOV | 16'h03FF);
		send(OP_MOVW | 16'h00F0);
		send(OP_MOVW | 16'h000F);
		send(OP_IN | 16'h060F);
		send(OP_LDI | 16'h00E0);
		send(OP_LDI | 16'h01F1);
		send(OP_STD | 16'h2DF7);
		send(OP_LDD | 16'h2CF7);
		send(OP_PUSH | 16'h01F0);
		send(OP_PUSH | 16'h0000);
		send(OP_RJMP | 16'h07FF);
		send(OP_RJMP | 16'h0800);
		send(OP_RJMP | 16'h0FFF);
		repeat (480)
			send(random_op());
		end_with_break = $urandom_range(0, 1);
		send(end_with_break ? OP_BREAK : OP_UNDEF);
		send(OP_LDI | 16'h0FFF);
		send(OP_BREAK);
		send(OP_UNDEF);
		send(OP_ADD | 16'h03FF);

		wait (pending_words.size() == 0 && !push);
		wait (expected_outcomes.size() == 0);
		repeat (40) @(posedge clk);
		$display("Executed %0d instruction words, %0d results checked, halting on %s.",
			words_in, words_out, end_with_break ? "BREAK" : "an undefined word");
		if (errors == 0 && expected_outcomes.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

/* avr_subset_execute_core.f */
rtl/avrex_pkg.sv
rtl/avrex_front.sv
rtl/avrex_queue.sv
rtl/avrex_back.sv
rtl/avr_subset_execute_core.sv
sim/tb_avr_subset_execute_core.sv
